[src/srie_pkg.sv]
// Shared constants and command codes for the instruction executor.
package srie_pkg;

    localparam int REG_COUNT = 16;
    localparam int MEM_WORDS = 4096;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [15:0] PC_RESET = 16'd4000;
    localparam logic [15:0] PC_STEP  = 16'd4;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_ADDL   = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_SUBL   = 5'd3,
        CMD_MUL    = 5'd4,
        CMD_AND    = 5'd5,
        CMD_OR     = 5'd6,
        CMD_XOR    = 5'd7,
        CMD_MOVC   = 5'd8,
        CMD_LOAD   = 5'd9,
        CMD_LOADP  = 5'd10,
        CMD_STORE  = 5'd11,
        CMD_STOREP = 5'd12,
        CMD_CMP    = 5'd13,
        CMD_CML    = 5'd14,
        CMD_BZ     = 5'd15,
        CMD_BNZ    = 5'd16,
        CMD_BP     = 5'd17,
        CMD_BNP    = 5'd18,
        CMD_BN     = 5'd19,
        CMD_BNN    = 5'd20,
        CMD_JUMP   = 5'd21,
        CMD_JALR   = 5'd22,
        CMD_NOP    = 5'd23,
        CMD_HALT   = 5'd24
    } cmd_t;

endpackage

[src/simple_risc_instruction_executor.sv]
// Top level of the instruction executor: register file, data memory, execute and result stages.

// Executes one decoded instruction per cycle, sustained while m_ready stays high. An accepted
// item passes through the execute stage (register file read data, ALU, multiplier, address
// add, flags and PC) and then sits in the result register, which also holds the data memory
// read; the result is offered from there. Register values are forwarded from the result stage
// and from a write that lands on the read edge, so dependent instructions, loads included,
// follow with no bubble. The execute stage takes a new item while a result waits in the result
// register, provided the execute stage is empty. After reset the data memory is swept to zero
// at one word per cycle over all MEM_WORDS (4096) words; s_ready stays low until the sweep ends.
module simple_risc_instruction_executor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_command,
    input  logic [3:0]         s_dest_reg,
    input  logic [3:0]         s_src1_reg,
    input  logic [3:0]         s_src2_reg,
    input  logic signed [31:0] s_immediate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_reg_write,
    output logic [3:0]         m_reg_index,
    output logic signed [31:0] m_reg_value,
    output logic               m_mem_write,
    output logic [11:0]        m_mem_address,
    output logic signed [31:0] m_mem_value,
    output logic               m_branch_taken,
    output logic [15:0]        m_next_pc,
    output logic [2:0]         m_flags,
    output logic               m_bad_address,
    output logic               m_halted
);
    import srie_pkg::*;

    // memory sweep after reset
    logic              clr_busy_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    // architectural state outside the memories
    logic [15:0] pc_reg;
    logic        flag_z_reg, flag_n_reg, flag_p_reg;

    // register file
    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [31:0]          rf_rdata_a_reg, rf_rdata_b_reg;
    logic                 rf_we;
    logic [REG_AW-1:0]    rf_waddr;
    logic [31:0]          rf_wdata;
    logic [REG_AW-1:0]    rf_raddr_a, rf_raddr_b;

    // data memory
    logic [31:0]       dm_mem [MEM_WORDS];
    logic [31:0]       dm_rdata_reg;
    logic              dm_we, dm_re;
    logic [MEM_AW-1:0] dm_waddr, dm_raddr;
    logic [31:0]       dm_wdata;

    // execute stage
    logic        s1_valid_reg;
    logic [4:0]  s1_cmd_reg;
    logic [3:0]  s1_rd_reg, s1_src1_reg, s1_src2_reg;
    logic [31:0] s1_imm_reg;
    logic        s1_ok_a_reg, s1_ok_b_reg;
    logic        s1_rfv_a_reg, s1_rfv_b_reg;
    logic        s1_byp_a_reg, s1_byp_b_reg;
    logic [31:0] s1_byp_data_reg;

    // result stage
    logic        s2_valid_reg;
    logic        s2_wr_reg;
    logic [3:0]  s2_idx_reg;
    logic [31:0] s2_val_reg;
    logic        s2_load_reg;
    logic        s2_bad_reg;
    logic        s2_mw_reg;
    logic [11:0] s2_addr_reg;
    logic [31:0] s2_mval_reg;
    logic        s2_taken_reg;
    logic [15:0] s2_next_pc_reg;
    logic [2:0]  s2_flags_reg;
    logic        s2_halt_reg;

    logic s_accept, s1_en, s2_adv, s1_adv, m_accept;

    assign m_accept = m_valid && m_ready;
    assign s2_adv   = !s2_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && s2_adv;
    assign s1_en    = !s1_valid_reg || s2_adv;
    assign s_ready  = s1_en && !clr_busy_reg;
    assign s_accept = s_valid && s_ready;

    // ---------------------------------------------------------------- result stage values
    logic [31:0] s2_load_data, s2_wval;
    assign s2_load_data = s2_bad_reg ? 32'd0 : dm_rdata_reg;
    assign s2_wval      = s2_load_reg ? s2_load_data : s2_val_reg;

    // ---------------------------------------------------------------- register file
    assign rf_we      = m_accept && s2_wr_reg;
    assign rf_waddr   = REG_AW'(s2_idx_reg);
    assign rf_wdata   = s2_wval;
    assign rf_raddr_a = REG_AW'(s_src1_reg);
    assign rf_raddr_b = REG_AW'(s_src2_reg);

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (s_accept) begin
            rf_rdata_a_reg <= rf_mem[rf_raddr_a];
            rf_rdata_b_reg <= rf_mem[rf_raddr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (rf_we) begin
            rf_valid_reg[rf_waddr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- execute stage
    logic [31:0] op_a, op_b;
    logic [31:0] sum_ab, diff_ab, sum_ai, diff_ai, prod_ab;
    logic        sum_bad;

    always_comb begin
        if (!s1_ok_a_reg) begin
            op_a = 32'd0;
        end else if (s2_valid_reg && s2_wr_reg && s2_idx_reg == s1_src1_reg) begin
            op_a = s2_wval;
        end else if (s1_byp_a_reg) begin
            op_a = s1_byp_data_reg;
        end else if (s1_rfv_a_reg) begin
            op_a = rf_rdata_a_reg;
        end else begin
            op_a = 32'd0;
        end
    end

    always_comb begin
        if (!s1_ok_b_reg) begin
            op_b = 32'd0;
        end else if (s2_valid_reg && s2_wr_reg && s2_idx_reg == s1_src2_reg) begin
            op_b = s2_wval;
        end else if (s1_byp_b_reg) begin
            op_b = s1_byp_data_reg;
        end else if (s1_rfv_b_reg) begin
            op_b = rf_rdata_b_reg;
        end else begin
            op_b = 32'd0;
        end
    end

    assign sum_ab  = op_a + op_b;
    assign diff_ab = op_a - op_b;
    assign sum_ai  = op_a + s1_imm_reg;
    assign diff_ai = op_a - s1_imm_reg;
    assign prod_ab = op_a * op_b;
    assign sum_bad = sum_ai >= 32'(MEM_WORDS);

    logic        ex_wr, ex_load, ex_store, ex_mem, ex_taken, ex_halt, ex_cond, ex_branch;
    logic        ex_cmp, ex_cmp_eq, ex_cmp_lt;
    logic [31:0] ex_val, ex_cmp_rhs;
    logic [15:0] pc_next;
    logic        flag_z_next, flag_n_next, flag_p_next;

    always_comb begin
        ex_wr       = 1'b0;
        ex_val      = 32'd0;
        ex_load     = 1'b0;
        ex_store    = 1'b0;
        ex_mem      = 1'b0;
        ex_taken    = 1'b0;
        ex_halt     = 1'b0;
        ex_cond     = 1'b0;
        ex_branch   = 1'b0;
        ex_cmp      = 1'b0;
        ex_cmp_rhs  = op_b;
        pc_next     = pc_reg + PC_STEP;
        flag_z_next = flag_z_reg;
        flag_n_next = flag_n_reg;
        flag_p_next = flag_p_reg;
        case (s1_cmd_reg)
            CMD_ADD:  begin ex_wr = 1'b1; ex_val = sum_ab;  flag_z_next = (sum_ab == 32'd0);  end
            CMD_ADDL: begin ex_wr = 1'b1; ex_val = sum_ai;  flag_z_next = (sum_ai == 32'd0);  end
            CMD_SUB:  begin ex_wr = 1'b1; ex_val = diff_ab; flag_z_next = (diff_ab == 32'd0); end
            CMD_SUBL: begin ex_wr = 1'b1; ex_val = diff_ai; flag_z_next = (diff_ai == 32'd0); end
            CMD_MUL:  begin ex_wr = 1'b1; ex_val = prod_ab; end
            CMD_AND: begin
                ex_wr       = 1'b1;
                ex_val      = op_a & op_b;
                flag_z_next = ((op_a & op_b) == 32'd0);
            end
            CMD_OR:   begin ex_wr = 1'b1; ex_val = op_a | op_b; end
            CMD_XOR:  begin ex_wr = 1'b1; ex_val = op_a ^ op_b; end
            CMD_MOVC: begin
                ex_wr       = 1'b1;
                ex_val      = s1_imm_reg;
                flag_z_next = (s1_imm_reg == 32'd0);
            end
            CMD_LOAD, CMD_LOADP: begin
                ex_wr   = 1'b1;
                ex_load = 1'b1;
                ex_mem  = 1'b1;
            end
            CMD_STORE, CMD_STOREP: begin
                ex_store = 1'b1;
                ex_mem   = 1'b1;
            end
            CMD_CMP: ex_cmp = 1'b1;
            CMD_CML: begin
                ex_cmp     = 1'b1;
                ex_cmp_rhs = s1_imm_reg;
            end
            CMD_BZ:  begin ex_branch = 1'b1; ex_cond = flag_z_reg;  end
            CMD_BNZ: begin ex_branch = 1'b1; ex_cond = !flag_z_reg; end
            CMD_BP:  begin ex_branch = 1'b1; ex_cond = flag_p_reg;  end
            CMD_BNP: begin ex_branch = 1'b1; ex_cond = !flag_p_reg; end
            CMD_BN:  begin ex_branch = 1'b1; ex_cond = flag_n_reg;  end
            CMD_BNN: begin ex_branch = 1'b1; ex_cond = !flag_n_reg; end
            CMD_JUMP: begin
                ex_taken = 1'b1;
                pc_next  = sum_ai[15:0];
            end
            CMD_JALR: begin
                ex_taken = 1'b1;
                pc_next  = sum_ai[15:0];
                ex_wr    = 1'b1;
                ex_val   = {16'd0, pc_reg + PC_STEP};
            end
            CMD_HALT: ex_halt = 1'b1;
            default: ;
        endcase

        ex_cmp_eq = (op_a == ex_cmp_rhs);
        ex_cmp_lt = ($signed(op_a) < $signed(ex_cmp_rhs));
        if (ex_cmp) begin
            flag_z_next = ex_cmp_eq;
            flag_n_next = !ex_cmp_eq && ex_cmp_lt;
            flag_p_next = !ex_cmp_eq && !ex_cmp_lt;
        end

        if (ex_branch && ex_cond) begin
            ex_taken = 1'b1;
            pc_next  = pc_reg + s1_imm_reg[15:0];
        end

        // drop a write to a register number beyond the file
        if (ex_wr && !(32'(s1_rd_reg) < REG_COUNT)) begin
            ex_wr = 1'b0;
        end
    end

    // ---------------------------------------------------------------- data memory
    always_comb begin
        if (clr_busy_reg) begin
            dm_we    = 1'b1;
            dm_waddr = clr_addr_reg;
            dm_wdata = 32'd0;
        end else begin
            dm_we    = s1_adv && ex_store && !sum_bad;
            dm_waddr = MEM_AW'(sum_ai);
            dm_wdata = op_b;
        end
    end
    assign dm_re    = s1_adv && ex_load && !sum_bad;
    assign dm_raddr = MEM_AW'(sum_ai);

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        if (dm_re) begin
            dm_rdata_reg <= dm_mem[dm_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == MEM_AW'(MEM_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= PC_RESET;
            flag_z_reg   <= 1'b0;
            flag_n_reg   <= 1'b0;
            flag_p_reg   <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= s_accept;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_adv) begin
                pc_reg     <= pc_next;
                flag_z_reg <= flag_z_next;
                flag_n_reg <= flag_n_next;
                flag_p_reg <= flag_p_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg   <= s_command;
            s1_rd_reg    <= s_dest_reg;
            s1_src1_reg  <= s_src1_reg;
            s1_src2_reg  <= s_src2_reg;
            s1_imm_reg   <= s_immediate;
            s1_ok_a_reg  <= 32'(s_src1_reg) < REG_COUNT;
            s1_ok_b_reg  <= 32'(s_src2_reg) < REG_COUNT;
            s1_rfv_a_reg <= rf_valid_reg[rf_raddr_a];
            s1_rfv_b_reg <= rf_valid_reg[rf_raddr_b];
            // catch a write that lands on the read edge
            s1_byp_a_reg    <= rf_we && rf_waddr == rf_raddr_a;
            s1_byp_b_reg    <= rf_we && rf_waddr == rf_raddr_b;
            s1_byp_data_reg <= rf_wdata;
        end
        if (s1_adv) begin
            s2_wr_reg      <= ex_wr;
            s2_idx_reg     <= ex_wr ? s1_rd_reg : 4'd0;
            s2_val_reg     <= ex_wr ? ex_val : 32'd0;
            s2_load_reg    <= ex_load;
            s2_bad_reg     <= ex_mem && sum_bad;
            s2_mw_reg      <= ex_store && !sum_bad;
            s2_addr_reg    <= ex_mem ? sum_ai[11:0] : 12'd0;
            s2_mval_reg    <= ex_store ? op_b : 32'd0;
            s2_taken_reg   <= ex_taken;
            s2_next_pc_reg <= pc_next;
            s2_flags_reg   <= {flag_p_next, flag_n_next, flag_z_next};
            s2_halt_reg    <= ex_halt;
        end
    end

    // ---------------------------------------------------------------- result channel
    assign m_valid        = s2_valid_reg;
    assign m_reg_write    = s2_wr_reg;
    assign m_reg_index    = s2_idx_reg;
    assign m_reg_value    = s2_wr_reg ? s2_wval : 32'd0;
    assign m_mem_write    = s2_mw_reg;
    assign m_mem_address  = s2_addr_reg;
    assign m_mem_value    = s2_load_reg ? s2_load_data : s2_mval_reg;
    assign m_branch_taken = s2_taken_reg;
    assign m_next_pc      = s2_next_pc_reg;
    assign m_flags        = s2_flags_reg;
    assign m_bad_address  = s2_bad_reg;
    assign m_halted       = s2_halt_reg;

endmodule

[src/srie_checker.sv]
// Port-level checker for the instruction executor, bound to the top level.
module srie_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_reg_write,
    input logic [3:0]         m_reg_index,
    input logic signed [31:0] m_reg_value,
    input logic               m_mem_write,
    input logic               m_bad_address,
    input logic               m_branch_taken,
    input logic               m_halted
);

    // hold a result until it is taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped before it was taken");

    // the memory sweep keeps input closed right after reset
    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during memory sweep");

    a_no_write_when_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_address |-> !m_mem_write)
        else $error("memory write reported for an address outside memory");

    a_halt_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_halted |-> !m_reg_write && !m_mem_write && !m_branch_taken)
        else $error("halt item reports a side effect");

    a_no_reg_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_write |-> m_reg_index == 4'd0 && m_reg_value == 32'sd0)
        else $error("register fields nonzero without a register write");

endmodule

bind simple_risc_instruction_executor srie_checker u_srie_checker (.*);

[sim/simple_risc_instruction_executor_tb.sv]
// Self-checking testbench for the instruction executor: directed and random programs.
module simple_risc_instruction_executor_tb;
    import srie_pkg::*;

    localparam logic [4:0] CMD_SPARE_LO = 5'd25;
    localparam logic [4:0] CMD_SPARE_HI = 5'd31;
    localparam int RANDOM_PER_PHASE = 375;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 20000;

    typedef struct packed {
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [11:0] mem_address;
        logic [31:0] mem_value;
        logic        branch_taken;
        logic [15:0] next_pc;
        logic [2:0]  flags;
        logic        bad_address;
        logic        halted;
    } retire_t;

    // Architectural shadow of the executor plus the queue of outcomes still owed by the block.
    class retire_checker;
        logic [31:0] regs [REG_COUNT];
        logic [31:0] dmem [MEM_WORDS];
        logic [15:0] pc;
        logic        zf, nf, pf;
        retire_t     expected_q[$];
        int          mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc = PC_RESET;
            zf = 1'b0;
            nf = 1'b0;
            pf = 1'b0;
            mismatches = 0;
        endfunction

        function logic [31:0] read_reg(logic [3:0] idx);
            return (int'(idx) < REG_COUNT) ? regs[idx] : 32'd0;
        endfunction

        function void set_compare(logic [31:0] x, logic [31:0] y);
            zf = (x == y);
            nf = (x != y) && ($signed(x) < $signed(y));
            pf = (x != y) && !($signed(x) < $signed(y));
        endfunction

        function void note_issue(logic [4:0] cmd, logic [3:0] rd, logic [3:0] rs1,
                                 logic [3:0] rs2, logic [31:0] imm);
            logic [31:0] a, b, val, addr;
            logic [15:0] nxt;
            logic        wr, cond;
            retire_t     r;
            a = read_reg(rs1);
            b = read_reg(rs2);
            nxt = pc + PC_STEP;
            r = '0;
            wr = 1'b0;
            cond = 1'b0;
            val = '0;
            addr = '0;
            case (cmd)
                CMD_ADD:  begin val = a + b;   wr = 1'b1; zf = (val == 0); end
                CMD_ADDL: begin val = a + imm; wr = 1'b1; zf = (val == 0); end
                CMD_SUB:  begin val = a - b;   wr = 1'b1; zf = (val == 0); end
                CMD_SUBL: begin val = a - imm; wr = 1'b1; zf = (val == 0); end
                CMD_MUL:  begin val = a * b;   wr = 1'b1; end
                CMD_AND:  begin val = a & b;   wr = 1'b1; zf = (val == 0); end
                CMD_OR:   begin val = a | b;   wr = 1'b1; end
                CMD_XOR:  begin val = a ^ b;   wr = 1'b1; end
                CMD_MOVC: begin val = imm;     wr = 1'b1; zf = (val == 0); end
                CMD_LOAD, CMD_LOADP: begin
                    addr = a + imm;
                    r.bad_address = (addr >= 32'(MEM_WORDS));
                    r.mem_value = r.bad_address ? 32'd0 : dmem[addr[MEM_AW-1:0]];
                    val = r.mem_value;
                    wr = 1'b1;
                end
                CMD_STORE, CMD_STOREP: begin
                    addr = a + imm;
                    r.bad_address = (addr >= 32'(MEM_WORDS));
                    r.mem_value = b;
                    // drop the write when the address misses memory
                    if (!r.bad_address) begin
                        dmem[addr[MEM_AW-1:0]] = b;
                        r.mem_write = 1'b1;
                    end
                end
                CMD_CMP: set_compare(a, b);
                CMD_CML: set_compare(a, imm);
                CMD_BZ:  cond = zf;
                CMD_BNZ: cond = !zf;
                CMD_BP:  cond = pf;
                CMD_BNP: cond = !pf;
                CMD_BN:  cond = nf;
                CMD_BNN: cond = !nf;
                CMD_JUMP: begin
                    nxt = a[15:0] + imm[15:0];
                    r.branch_taken = 1'b1;
                end
                CMD_JALR: begin
                    nxt = a[15:0] + imm[15:0];
                    r.branch_taken = 1'b1;
                    val = {16'd0, pc + PC_STEP};
                    wr = 1'b1;
                end
                CMD_HALT: r.halted = 1'b1;
                default: ;
            endcase
            if (cond) begin
                nxt = pc + imm[15:0];
                r.branch_taken = 1'b1;
            end
            if (wr && int'(rd) < REG_COUNT) begin
                regs[rd] = val;
                r.reg_write = 1'b1;
                r.reg_index = rd;
                r.reg_value = val;
            end
            pc = nxt;
            r.mem_address = addr[11:0];
            r.next_pc = nxt;
            r.flags = {pf, nf, zf};
            expected_q.push_back(r);
        endfunction

        function void check_retire(retire_t got);
            retire_t want;
            string   diff;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: %p", got);
                return;
            end
            want = expected_q.pop_front();
            diff = "";
            if (got.reg_write    !== want.reg_write)    diff = {diff, " reg_write"};
            if (got.reg_index    !== want.reg_index)    diff = {diff, " reg_index"};
            if (got.reg_value    !== want.reg_value)    diff = {diff, " reg_value"};
            if (got.mem_write    !== want.mem_write)    diff = {diff, " mem_write"};
            if (got.mem_address  !== want.mem_address)  diff = {diff, " mem_address"};
            if (got.mem_value    !== want.mem_value)    diff = {diff, " mem_value"};
            if (got.branch_taken !== want.branch_taken) diff = {diff, " branch_taken"};
            if (got.next_pc      !== want.next_pc)      diff = {diff, " next_pc"};
            if (got.flags        !== want.flags)        diff = {diff, " flags"};
            if (got.bad_address  !== want.bad_address)  diff = {diff, " bad_address"};
            if (got.halted       !== want.halted)       diff = {diff, " halted"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in%s: expected %p, got %p", diff, want, got);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_command = '0;
    logic [3:0]  s_dest_reg = '0;
    logic [3:0]  s_src1_reg = '0;
    logic [3:0]  s_src2_reg = '0;
    logic signed [31:0] s_immediate = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_reg_write;
    logic [3:0]  m_reg_index;
    logic signed [31:0] m_reg_value;
    logic        m_mem_write;
    logic [11:0] m_mem_address;
    logic signed [31:0] m_mem_value;
    logic        m_branch_taken;
    logic [15:0] m_next_pc;
    logic [2:0]  m_flags;
    logic        m_bad_address;
    logic        m_halted;

    retire_checker sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    simple_risc_instruction_executor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_dest_reg     (s_dest_reg),
        .s_src1_reg     (s_src1_reg),
        .s_src2_reg     (s_src2_reg),
        .s_immediate    (s_immediate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_write    (m_reg_write),
        .m_reg_index    (m_reg_index),
        .m_reg_value    (m_reg_value),
        .m_mem_write    (m_mem_write),
        .m_mem_address  (m_mem_address),
        .m_mem_value    (m_mem_value),
        .m_branch_taken (m_branch_taken),
        .m_next_pc      (m_next_pc),
        .m_flags        (m_flags),
        .m_bad_address  (m_bad_address),
        .m_halted       (m_halted)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 32'(int'($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    // Mostly a handful of low words so loads see earlier stores; some misses past the end.
    function automatic logic [31:0] pick_address();
        int unsigned sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(0, 31);
        if (sel < 88) return $urandom_range(0, MEM_WORDS - 1);
        if (sel < 94) return MEM_WORDS;
        return $urandom_range(MEM_WORDS, 32'hFFFF_FFFF);
    endfunction

    task automatic offer(logic [4:0] cmd, logic [3:0] rd, logic [3:0] rs1, logic [3:0] rs2,
                         logic [31:0] imm);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_dest_reg  <= rd;
        s_src1_reg  <= rs1;
        s_src2_reg  <= rs2;
        s_immediate <= imm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_issue(cmd, rd, rs1, rs2, imm);
    endtask

    task automatic send_random();
        logic [4:0]  cmd;
        logic [3:0]  rd, rs1, rs2;
        logic [31:0] imm;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        rd  = 4'($urandom());
        rs1 = 4'($urandom());
        rs2 = 4'($urandom());
        imm = pick_imm();
        if (pick < 12) begin
            cmd = CMD_MOVC;
        end else if (pick < 40) begin
            cmd = 5'($urandom_range(CMD_ADD, CMD_XOR));
        end else if (pick < 62) begin
            cmd = 5'($urandom_range(CMD_LOAD, CMD_STOREP));
            imm = pick_address() - sb.read_reg(rs1);
        end else if (pick < 72) begin
            cmd = $urandom_range(0, 1) ? CMD_CMP : CMD_CML;
        end else if (pick < 86) begin
            cmd = 5'($urandom_range(CMD_BZ, CMD_BNN));
        end else if (pick < 92) begin
            cmd = $urandom_range(0, 1) ? CMD_JUMP : CMD_JALR;
        end else if (pick < 96) begin
            cmd = $urandom_range(0, 1) ? CMD_NOP : CMD_HALT;
        end else begin
            cmd = 5'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        offer(cmd, rd, rs1, rs2, imm);
    endtask

    // Hold off new items until the block has returned every outstanding result.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_retire('{m_reg_write, m_reg_index, m_reg_value, m_mem_write,
                                  m_mem_address, m_mem_value, m_branch_taken, m_next_pc,
                                  m_flags, m_bad_address, m_halted});
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, wraparound and the flag setters
        offer(CMD_MOVC, 4'd1, 4'd0, 4'd0, 32'h7FFF_FFFF);
        offer(CMD_MOVC, 4'd2, 4'd0, 4'd0, 32'h8000_0000);
        offer(CMD_ADD,  4'd3, 4'd1, 4'd2, 32'd0);
        offer(CMD_ADDL, 4'd4, 4'd1, 4'd0, 32'd1);
        offer(CMD_SUB,  4'd5, 4'd2, 4'd1, 32'd0);
        offer(CMD_SUBL, 4'd0, 4'd0, 4'd0, 32'd0);
        offer(CMD_BZ,   4'd0, 4'd0, 4'd0, 32'd12);
        offer(CMD_MUL,  4'd6, 4'd1, 4'd2, 32'd0);
        offer(CMD_AND,  4'd7, 4'd1, 4'd2, 32'd0);
        offer(CMD_OR,   4'd8, 4'd1, 4'd2, 32'd0);
        offer(CMD_XOR,  4'd9, 4'd1, 4'd1, 32'd0);
        offer(CMD_CML,  4'd0, 4'd1, 4'd0, 32'h8000_0000);
        offer(CMD_BP,   4'd0, 4'd0, 4'd0, 32'hFFFF_FFFC);
        offer(CMD_BNP,  4'd0, 4'd0, 4'd0, 32'd8);
        offer(CMD_CMP,  4'd0, 4'd2, 4'd1, 32'd0);
        offer(CMD_BN,   4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF);
        offer(CMD_BNN,  4'd0, 4'd0, 4'd0, 32'd16);
        offer(CMD_BNZ,  4'd0, 4'd0, 4'd0, 32'd20);
        // last word of memory, then one past it, then a wrapped negative address
        offer(CMD_MOVC,   4'd10, 4'd0,  4'd0, 32'd4095);
        offer(CMD_STORE,  4'd0,  4'd10, 4'd2, 32'd0);
        offer(CMD_LOADP,  4'd11, 4'd10, 4'd0, 32'd0);
        offer(CMD_STOREP, 4'd0,  4'd10, 4'd1, 32'd1);
        offer(CMD_LOAD,   4'd12, 4'd0,  4'd0, 32'hFFFF_FFFF);
        offer(CMD_JUMP,   4'd0,  4'd1,  4'd0, 32'd1);
        offer(CMD_JALR,   4'd15, 4'd10, 4'd0, 32'h8000_0000);
        offer(CMD_NOP,    4'd0,  4'd0,  4'd0, 32'd0);
        offer(CMD_HALT,   4'd0,  4'd0,  4'd0, 32'd0);
        offer(CMD_SPARE_LO, 4'd3, 4'd3, 4'd3, 32'd0);
        offer(CMD_SPARE_HI, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random();
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
